// ----- rtl/ced_pkg.sv -----
// Shared package of the cross-entropy categorical update block.
// Holds field widths, reset values, command codes and the controller/datapath structs.
// No dependencies.
`default_nettype none

package ced_pkg;

  // Defaults of the top-level parameters.
  localparam int DEF_ROWS       = 64;
  localparam int DEF_CHOICES    = 16;
  localparam int DEF_COUNT_BITS = 8;

  // Fixed field widths.
  localparam int PROB_W        = 16;
  localparam int RATE_W        = 16;
  localparam int CMD_W         = 2;
  localparam int ROW_IDX_W     = 6;
  localparam int CH_IDX_W      = 4;
  localparam int ECOUNT_W      = 8;
  localparam int CHOICES_CFG_W = 5;
  localparam int ROWS_CFG_W    = 7;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 2;

  // Quotient of the shared divider: 17 bits covers every blended probability
  // before saturation and the uniform value for a single option.
  localparam int QUO_W     = 17;
  localparam int QUO_CNT_W = 5;

  localparam logic [QUO_W-1:0]  PROB_ONE  = 17'h10000;  // 1.0 in Q1.16
  localparam logic [QUO_W-1:0]  PROB_HALF = 17'h08000;  // rounding offset
  localparam logic [PROB_W-1:0] PROB_MAX  = 16'hFFFF;

  // Reset values of the configuration registers.
  localparam logic [RATE_W-1:0]        RATE_RESET    = 16'h8000;
  localparam logic [CHOICES_CFG_W-1:0] CHOICES_RESET = 5'd16;
  localparam logic [ROWS_CFG_W-1:0]    ROWS_RESET    = 7'd64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHOICES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_COUNT  = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_INIT   = 2'd3
  } cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic clr_init;
    logic clr_step;
    logic row_init;
    logic row_next;
    logic ch_next;
    logic ch_restart;
    logic sum_acc;
    logic mul_first;
    logic mul_second;
    logic div_upd;
    logic div_uni;
    logic uni_take;
    logic uni_write;
    logic upd_write;
    logic cnt_write;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic last_ch;
    logic last_row;
    logic clr_last;
    logic sum_zero;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/ced_if.sv -----
// Handshake interfaces of the input item channel and the result channel.
// Depends on ced_pkg for the payload widths.
`default_nettype none

interface ced_in_if;
  logic                             valid;
  logic                             ready;
  logic [ced_pkg::CMD_W-1:0]        command;
  logic [ced_pkg::ROW_IDX_W-1:0]    row_index;
  logic [ced_pkg::CH_IDX_W-1:0]     choice_index;

  modport source (output valid, command, row_index, choice_index, input ready);
  modport sink   (input valid, command, row_index, choice_index, output ready);
endinterface

interface ced_out_if;
  logic                             valid;
  logic                             ready;
  logic [ced_pkg::PROB_W-1:0]       probability;
  logic [ced_pkg::ECOUNT_W-1:0]     elite_count;
  logic                             done_res;

  modport source (output valid, probability, elite_count, done_res, input ready);
  modport sink   (input valid, probability, elite_count, done_res, output ready);
endinterface

`default_nettype wire

// ----- rtl/cross_entropy_categorical_update_unit.sv -----
// Top level of the cross-entropy categorical update block: controller,
// datapath and the channel interfaces. Depends on ced_pkg, ced_if, ced_ctrl, ced_dp.
//
// Usage. Items arrive on in_ch (command, row_index, choice_index) and each
// yields exactly one result on out_ch (probability, elite_count, done_res);
// a transfer happens when valid and ready are both high. One item is worked
// on at a time; in_ch.ready returns with the result, so a new item is taken
// only once the result of the last one is loaded. A uniform init divides 1.0
// by the options in use, fills the rows in use and then clears every count.
// An update sums the counts of each row in use, then, for each option of a
// row with a nonzero sum, reads, multiplies in two steps and divides on the
// bit-serial divider (one quotient bit per cycle; the first option of a row
// skips the read) before writing back, and ends with the sweep that clears
// every count. The count memory is swept one entry per cycle.
// After reset the block runs the same clearing sweep with in_ch.ready low;
// configuration writes are taken all the while. The result sits in an
// output register, so when the receiver stalls the block still finishes the
// next item and waits only before loading its result.
// Configuration is written through cfg_we, cfg_index and cfg_data while idle.
`default_nettype none

module cross_entropy_categorical_update_unit #(
  parameter int ROWS       = ced_pkg::DEF_ROWS,
  parameter int CHOICES    = ced_pkg::DEF_CHOICES,
  parameter int COUNT_BITS = ced_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ced_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ced_pkg::CFG_DATA_W-1:0] cfg_data,
  ced_in_if.sink                         in_ch,
  ced_out_if.source                      out_ch
);
  import ced_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sees only status and the input handshake; it never touches the payload.
  ced_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ced_dp #(
    .ROWS       (ROWS),
    .CHOICES    (CHOICES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_command      (in_ch.command),
    .in_row_index    (in_ch.row_index),
    .in_choice_index (in_ch.choice_index),
    .out_ready       (out_ch.ready),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_ch.valid),
    .out_probability (out_ch.probability),
    .out_elite_count (out_ch.elite_count)
  );

  // Every result marks a completed command.
  assign out_ch.done_res = 1'b1;

  // The block holds one item at a time: right after a transfer in, it is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an item is still in progress");

  // A new result only appears right after the block was busy.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result appeared without a command in progress");

  // The divider is never left running while the block waits for an item.
  a_div_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !stat.div_busy)
    else $error("divider busy while the block is idle");

endmodule

`default_nettype wire

// ----- rtl/ced_div.sv -----
// Restoring divider, one quotient bit per cycle, 17 quotient bits.
// Depends on ced_pkg; the dividend shifted right by 17 must be below the divisor.
`default_nettype none

module ced_div #(
  parameter int DVD_W = 25,
  parameter int DVS_W = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [DVD_W-1:0]          dividend,
  input  logic [DVS_W-1:0]          divisor,
  output logic                      busy,
  output logic [ced_pkg::QUO_W-1:0] quotient
);
  import ced_pkg::*;

  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     dvs_r;
  logic [QUO_W-1:0]     qd_r;      // remaining dividend bits, quotient shifts in below
  logic [QUO_CNT_W-1:0] cnt_r;
  logic                 busy_r;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           fits;

  assign trial = {rem_r, qd_r[QUO_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= QUO_CNT_W'(QUO_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DVS_W'(dividend >> QUO_W);
      qd_r  <= dividend[QUO_W-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      qd_r  <= {qd_r[QUO_W-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign quotient = qd_r;

endmodule

`default_nettype wire

// ----- rtl/ced_dp.sv -----
// Datapath: configuration registers, probability and count memories, address
// counters, blend multipliers, the shared divider and the result register.
// Depends on ced_pkg and ced_div.
`default_nettype none

module ced_dp #(
  parameter int ROWS       = ced_pkg::DEF_ROWS,
  parameter int CHOICES    = ced_pkg::DEF_CHOICES,
  parameter int COUNT_BITS = ced_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ced_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ced_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [ced_pkg::CMD_W-1:0]      in_command,
  input  logic [ced_pkg::ROW_IDX_W-1:0]  in_row_index,
  input  logic [ced_pkg::CH_IDX_W-1:0]   in_choice_index,
  input  logic                           out_ready,
  input  ced_pkg::dp_cmd_t               cmd,
  output ced_pkg::dp_stat_t              stat,
  output logic                           out_valid,
  output logic [ced_pkg::PROB_W-1:0]     out_probability,
  output logic [ced_pkg::ECOUNT_W-1:0]   out_elite_count
);
  import ced_pkg::*;

  localparam int TABLE     = ROWS * CHOICES;
  localparam int AW        = (TABLE > 1) ? $clog2(TABLE) : 1;
  localparam int CHW       = $clog2(CHOICES);
  localparam int RIW       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW        = $clog2(CHOICES + 1);
  localparam int RW        = $clog2(ROWS + 1);
  localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;
  localparam int SW        = $clog2(CHOICES * COUNT_MAX + 1);
  localparam int A_W       = 2 * PROB_W;
  localparam int RC_W      = RATE_W + COUNT_BITS;
  localparam int T_W       = QUO_W + SW;
  localparam int YW        = ((RC_W > SW + 1) ? RC_W : SW + 1) + 1;

  localparam logic [COUNT_BITS-1:0] CNT_SAT = '1;

  // Configuration registers and their clamped values.
  logic [RATE_W-1:0]        rate_r;
  logic [CHOICES_CFG_W-1:0] choices_r;
  logic [ROWS_CFG_W-1:0]    rows_r;
  logic [CW-1:0]            c_eff;
  logic [RW-1:0]            r_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r    <= RATE_RESET;
      choices_r <= CHOICES_RESET;
      rows_r    <= ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RATE:    rate_r    <= cfg_data[RATE_W-1:0];
        REG_CHOICES: choices_r <= cfg_data[CHOICES_CFG_W-1:0];
        REG_ROWS:    rows_r    <= cfg_data[ROWS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (choices_r == '0) begin
      c_eff = CW'(1);
    end else if (32'(choices_r) > CHOICES) begin
      c_eff = CW'(CHOICES);
    end else begin
      c_eff = CW'(choices_r);
    end
    if (rows_r == '0) begin
      r_eff = RW'(1);
    end else if (32'(rows_r) > ROWS) begin
      r_eff = RW'(ROWS);
    end else begin
      r_eff = RW'(rows_r);
    end
  end

  // Captured item.
  cmd_t                 cmd_r;
  logic [ROW_IDX_W-1:0] row_r;
  logic [CH_IDX_W-1:0]  ch_r;
  logic                 in_use;
  logic                 in_table;
  logic [AW-1:0]        item_addr;

  assign item_addr = AW'(32'(in_row_index) * CHOICES + 32'(in_choice_index));
  assign in_use    = (32'(row_r) < 32'(r_eff)) && (32'(ch_r) < 32'(c_eff));
  assign in_table  = (32'(row_r) < ROWS) && (32'(ch_r) < CHOICES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= CMD_COUNT;
    end else if (cmd.load_item) begin
      cmd_r <= cmd_t'(in_command);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      row_r <= in_row_index;
      ch_r  <= in_choice_index;
    end
  end

  // Address walk: a linear sweep for clearing, row base plus choice otherwise.
  logic [AW-1:0]  addr_r;
  logic [AW-1:0]  row_base_r;
  logic [RIW-1:0] row_cnt_r;
  logic [CHW-1:0] ch_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r     <= '0;
      row_base_r <= '0;
      row_cnt_r  <= '0;
      ch_cnt_r   <= '0;
    end else if (cmd.load_item) begin
      addr_r <= item_addr;
    end else if (cmd.clr_init) begin
      addr_r <= '0;
    end else if (cmd.clr_step) begin
      addr_r <= addr_r + 1'b1;
    end else if (cmd.row_init) begin
      addr_r     <= '0;
      row_base_r <= '0;
      row_cnt_r  <= '0;
      ch_cnt_r   <= '0;
    end else if (cmd.row_next) begin
      addr_r     <= row_base_r + AW'(CHOICES);
      row_base_r <= row_base_r + AW'(CHOICES);
      row_cnt_r  <= row_cnt_r + 1'b1;
      ch_cnt_r   <= '0;
    end else if (cmd.ch_next) begin
      addr_r   <= addr_r + 1'b1;
      ch_cnt_r <= ch_cnt_r + 1'b1;
    end else if (cmd.ch_restart) begin
      addr_r   <= row_base_r;
      ch_cnt_r <= '0;
    end
  end

  // Memories, both read every cycle at the current address.
  logic [COUNT_BITS-1:0] cnt_mem [TABLE];
  logic [PROB_W-1:0]     prob_mem [TABLE];
  logic [COUNT_BITS-1:0] cnt_q_r;
  logic [PROB_W-1:0]     prob_q_r;
  logic                  cnt_we;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic                  prob_we;
  logic [PROB_W-1:0]     prob_wdata;

  assign cnt_we    = cmd.clr_step | (cmd.cnt_write & in_use & (cnt_q_r != CNT_SAT));
  assign cnt_wdata = cmd.clr_step ? '0 : cnt_q_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[addr_r] <= cnt_wdata;
    end
    cnt_q_r <= cnt_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (prob_we) begin
      prob_mem[addr_r] <= prob_wdata;
    end
    prob_q_r <= prob_mem[addr_r];
  end

  // Row sum of the elite counts.
  logic [SW-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (cmd.row_init || cmd.row_next) begin
      sum_r <= '0;
    end else if (cmd.sum_acc) begin
      sum_r <= sum_r + SW'(cnt_q_r);
    end
  end

  // Blend: p' = Ah + floor((r*cnt + (((Al + 0.5) * s) >> 16)) / s), where
  // (1 - r) * p = Ah * 2^16 + Al. This is the rounded blend, split so that no
  // product is wider than 24 by 17 bits.
  logic [QUO_W-1:0] rate_cmp;
  logic [A_W:0]     prod_a;
  logic [RC_W-1:0]  prod_rc;
  logic [QUO_W-1:0] al_rnd;
  logic [T_W-1:0]   prod_t;
  logic [A_W-1:0]   a_r;
  logic [RC_W-1:0]  rc_r;
  logic [T_W-1:0]   t_r;

  assign rate_cmp = PROB_ONE - {1'b0, rate_r};
  assign prod_a   = rate_cmp * prob_q_r;
  assign prod_rc  = rate_r * cnt_q_r;
  assign al_rnd   = {1'b0, a_r[PROB_W-1:0]} + PROB_HALF;
  assign prod_t   = al_rnd * sum_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_first) begin
      a_r  <= prod_a[A_W-1:0];
      rc_r <= prod_rc;
    end
    if (cmd.mul_second) begin
      t_r <= prod_t;
    end
  end

  // Shared divider: blend quotient, or 1.0 over the options in use.
  logic [YW-1:0]    dvd_upd;
  logic [YW-1:0]    div_dividend;
  logic [SW-1:0]    div_divisor;
  logic             div_busy;
  logic [QUO_W-1:0] div_quo;

  assign dvd_upd      = YW'(rc_r) + YW'(t_r[T_W-1:PROB_W]);
  assign div_dividend = cmd.div_uni ? YW'(PROB_ONE) : dvd_upd;
  assign div_divisor  = cmd.div_uni ? SW'(c_eff) : sum_r;

  ced_div #(
    .DVD_W (YW),
    .DVS_W (SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_upd | cmd.div_uni),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  logic [PROB_W-1:0]  uni_r;
  logic [PROB_W+1:0]  upd_sum;
  logic [PROB_W-1:0]  upd_val;

  assign upd_sum = {2'b00, a_r[A_W-1:PROB_W]} + {1'b0, div_quo};
  assign upd_val = (upd_sum > (PROB_W+2)'(PROB_MAX)) ? PROB_MAX : upd_sum[PROB_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.uni_take) begin
      uni_r <= div_quo[QUO_W-1] ? PROB_MAX : div_quo[PROB_W-1:0];
    end
  end

  assign prob_we    = cmd.uni_write | cmd.upd_write;
  assign prob_wdata = cmd.uni_write ? uni_r : upd_val;

  // Result register.
  logic                out_valid_r;
  logic [PROB_W-1:0]   out_prob_r;
  logic [ECOUNT_W-1:0] out_cnt_r;
  logic                read_hit;

  assign read_hit = (cmd_r == CMD_READ) && in_table;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_prob_r <= read_hit ? prob_q_r : '0;
      out_cnt_r  <= read_hit ? ECOUNT_W'(cnt_q_r) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_probability = out_prob_r;
  assign out_elite_count = out_cnt_r;

  assign stat.cmd      = cmd_r;
  assign stat.last_ch  = ch_cnt_r == CHW'(c_eff - 1'b1);
  assign stat.last_row = row_cnt_r == RIW'(r_eff - 1'b1);
  assign stat.clr_last = addr_r == AW'(TABLE - 1);
  assign stat.sum_zero = sum_r == '0;
  assign stat.div_busy = div_busy;
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire

// ----- rtl/ced_ctrl.sv -----
// Controller state machine: sequences count, read, uniform fill, update and
// count clearing sweeps through datapath commands. Depends on ced_pkg.
`default_nettype none

module ced_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ced_pkg::dp_stat_t stat,
  output ced_pkg::dp_cmd_t  cmd
);
  import ced_pkg::*;

  typedef enum logic [4:0] {
    S_BOOT,
    S_IDLE,
    S_DISPATCH,
    S_CNT_RD,
    S_CNT_WR,
    S_READ_RD,
    S_UNI_DIV,
    S_UNI_WAIT,
    S_UNI_FILL,
    S_SUM_RD,
    S_SUM_ACC,
    S_ROW_CHK,
    S_UPD_RD,
    S_UPD_MUL,
    S_UPD_MUL2,
    S_UPD_DIV,
    S_UPD_WAIT,
    S_UPD_WR,
    S_CLEAR,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   ready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_BOOT: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && ready_r) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.cmd)
          CMD_COUNT:  state_nxt = S_CNT_RD;
          CMD_READ:   state_nxt = S_READ_RD;
          CMD_INIT:   state_nxt = S_UNI_DIV;
          CMD_UPDATE: begin
            cmd.row_init = 1'b1;
            state_nxt    = S_SUM_RD;
          end
          default:    state_nxt = S_FINISH;
        endcase
      end
      S_CNT_RD:  state_nxt = S_CNT_WR;
      S_CNT_WR: begin
        cmd.cnt_write = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_READ_RD: state_nxt = S_FINISH;
      S_UNI_DIV: begin
        cmd.div_uni = 1'b1;
        state_nxt   = S_UNI_WAIT;
      end
      S_UNI_WAIT: begin
        if (!stat.div_busy) begin
          cmd.uni_take = 1'b1;
          cmd.row_init = 1'b1;
          state_nxt    = S_UNI_FILL;
        end
      end
      S_UNI_FILL: begin
        cmd.uni_write = 1'b1;
        if (!stat.last_ch) begin
          cmd.ch_next = 1'b1;
        end else if (!stat.last_row) begin
          cmd.row_next = 1'b1;
        end else begin
          cmd.clr_init = 1'b1;
          state_nxt    = S_CLEAR;
        end
      end
      S_SUM_RD:  state_nxt = S_SUM_ACC;
      S_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        if (stat.last_ch) begin
          cmd.ch_restart = 1'b1;
          state_nxt      = S_ROW_CHK;
        end else begin
          cmd.ch_next = 1'b1;
          state_nxt   = S_SUM_RD;
        end
      end
      S_ROW_CHK: begin
        // A row without elite counts keeps its probabilities.
        if (!stat.sum_zero) begin
          state_nxt = S_UPD_MUL;
        end else if (!stat.last_row) begin
          cmd.row_next = 1'b1;
          state_nxt    = S_SUM_RD;
        end else begin
          cmd.clr_init = 1'b1;
          state_nxt    = S_CLEAR;
        end
      end
      S_UPD_RD:  state_nxt = S_UPD_MUL;
      S_UPD_MUL: begin
        cmd.mul_first = 1'b1;
        state_nxt     = S_UPD_MUL2;
      end
      S_UPD_MUL2: begin
        cmd.mul_second = 1'b1;
        state_nxt      = S_UPD_DIV;
      end
      S_UPD_DIV: begin
        cmd.div_upd = 1'b1;
        state_nxt   = S_UPD_WAIT;
      end
      S_UPD_WAIT: begin
        if (!stat.div_busy) state_nxt = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd.upd_write = 1'b1;
        if (!stat.last_ch) begin
          cmd.ch_next = 1'b1;
          state_nxt   = S_UPD_RD;
        end else if (!stat.last_row) begin
          cmd.row_next = 1'b1;
          state_nxt    = S_SUM_RD;
        end else begin
          cmd.clr_init = 1'b1;
          state_nxt    = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BOOT;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = ready_r;

endmodule

`default_nettype wire

// ----- verif/tb_cross_entropy_categorical_update_unit.sv -----
// Self-checking testbench of cross_entropy_categorical_update_unit.
// Depends on ced_pkg, the ced_in_if/ced_out_if interfaces and the block's RTL.
// A cycle-free predictor of the distribution tables checks each transfer.
`timescale 1ns / 100ps

module tb_cross_entropy_categorical_update_unit;
  import ced_pkg::*;

  localparam int ROWS         = DEF_ROWS;
  localparam int CHOICES      = DEF_CHOICES;
  localparam int COUNT_BITS   = DEF_COUNT_BITS;
  localparam int ENTRIES      = ROWS * CHOICES;
  localparam int COUNT_MAX    = (1 << COUNT_BITS) - 1;
  localparam int LIMIT_CYCLES = 10000000;
  // The receiver holds off once for this many cycles after this many results.
  localparam int LONG_HOLD_AT     = 100;
  localparam int LONG_HOLD_CYCLES = 400;

  // One command as it travels on the input channel.
  typedef struct packed {
    cmd_t                 command;
    logic [ROW_IDX_W-1:0] row_index;
    logic [CH_IDX_W-1:0]  choice_index;
  } cmd_item_t;

  // One result as it should appear on the result channel.
  typedef struct packed {
    logic [PROB_W-1:0]   probability;
    logic [ECOUNT_W-1:0] elite_count;
    logic                done_res;
  } cmd_result_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ced_in_if  in_if ();
  ced_out_if out_if ();

  cross_entropy_categorical_update_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  // Predicted contents of the block: probabilities, elite counts and registers.
  bit [PROB_W-1:0]        prob_model  [ENTRIES];
  bit [COUNT_BITS-1:0]    count_model [ENTRIES];
  bit [RATE_W-1:0]        rate_cfg;
  bit [CHOICES_CFG_W-1:0] choices_cfg;
  bit [ROWS_CFG_W-1:0]    rows_cfg;

  cmd_item_t   pending_cmds[$];      // commands not yet offered to the block
  cmd_result_t expected_results[$];  // results of accepted commands, oldest first

  int unsigned items_queued;
  int unsigned results_seen;
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          idling_enabled;
  int unsigned in_gap_left;
  int unsigned out_stall_left;
  int unsigned long_hold_left;
  bit          long_hold_done;

  // Clock and the time-zero state of every input of the block.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_RATE;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.command = CMD_COUNT;
    in_if.row_index = '0;
    in_if.choice_index = '0;
    out_if.ready = 1'b0;
  end

  always #5 clk = ~clk;

  // Effective sizes: a register value of zero acts as one, and values above
  // the table size are clamped to it.
  function automatic int unsigned choices_limit();
    if (choices_cfg == 0) return 1;
    if (choices_cfg > CHOICES) return CHOICES;
    return choices_cfg;
  endfunction

  function automatic int unsigned rows_limit();
    if (rows_cfg == 0) return 1;
    if (rows_cfg > ROWS) return ROWS;
    return rows_cfg;
  endfunction

  // Applies one accepted command to the predicted tables and returns the
  // result the block must deliver for it.
  function automatic cmd_result_t apply_command(cmd_t cmd, logic [ROW_IDX_W-1:0] row,
                                                logic [CH_IDX_W-1:0] ch);
    cmd_result_t res;
    int unsigned nr;
    int unsigned nc;
    int unsigned base;
    int unsigned addr;
    bit [63:0]   rate;
    bit [63:0]   row_sum;
    bit [63:0]   num;
    bit [63:0]   den;
    bit [63:0]   quo;
    res = '0;
    res.done_res = 1'b1;
    nr = rows_limit();
    nc = choices_limit();
    case (cmd)
      CMD_COUNT: begin
        // A count outside the rows or options in use is dropped; counts saturate.
        if (row < nr && ch < nc) begin
          addr = row * CHOICES + ch;
          if (count_model[addr] < COUNT_MAX) count_model[addr]++;
        end
      end
      CMD_UPDATE: begin
        rate = 64'(rate_cfg);
        for (int r = 0; r < nr; r++) begin
          base = r * CHOICES;
          row_sum = 0;
          for (int c = 0; c < nc; c++) row_sum += count_model[base + c];
          // A row without elite samples keeps its probabilities.
          if (row_sum != 0) begin
            den = row_sum << 16;
            for (int c = 0; c < nc; c++) begin
              num = rate * 64'(count_model[base + c]) * 64'd65536
                  + (64'd65536 - rate) * 64'(prob_model[base + c]) * row_sum;
              quo = (num + (den >> 1)) / den;
              prob_model[base + c] = (quo > 64'd65535) ? PROB_MAX : quo[PROB_W-1:0];
            end
          end
        end
        foreach (count_model[i]) count_model[i] = '0;
      end
      CMD_READ: begin
        if (row < ROWS && ch < CHOICES) begin
          addr = row * CHOICES + ch;
          res.probability = prob_model[addr];
          res.elite_count = count_model[addr][ECOUNT_W-1:0];
        end
      end
      default: begin
        // Uniform init: with a single option 1.0 does not fit and saturates.
        quo = 64'd65536 / nc;
        if (quo > 64'd65535) quo = 64'd65535;
        for (int r = 0; r < nr; r++)
          for (int c = 0; c < nc; c++) prob_model[r * CHOICES + c] = quo[PROB_W-1:0];
        foreach (count_model[i]) count_model[i] = '0;
      end
    endcase
    return res;
  endfunction

  // Input side: offers queued commands, holding each until its transfer, and
  // records the predicted result at the edge where the transfer happens.
  always @(posedge clk) begin : drive_commands
    cmd_item_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready)
        expected_results = {expected_results,
                            apply_command(cmd_t'(in_if.command), in_if.row_index,
                                          in_if.choice_index)};
      if (!in_if.valid || in_if.ready) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          nxt = pending_cmds.pop_front();
          in_if.valid <= 1'b1;
          in_if.command <= nxt.command;
          in_if.row_index <= nxt.row_index;
          in_if.choice_index <= nxt.choice_index;
          // Now and then an idle burst follows this command.
          if (idling_enabled && $urandom_range(0, 5) == 0) in_gap_left = $urandom_range(1, 17);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Counts down the single long receiver hold-off that makes the block fill
  // up and push back on its input.
  always @(posedge clk) begin : long_hold
    if (!rst_n) begin
      long_hold_left <= 0;
    end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
      long_hold_left <= LONG_HOLD_CYCLES;
      long_hold_done <= 1'b1;
    end else if (long_hold_left > 0) begin
      long_hold_left <= long_hold_left - 1;
    end
  end

  // Result side: compares every transfer with the oldest expectation and
  // drives ready with random stalls and the long hold-off.
  always @(posedge clk) begin : check_results
    cmd_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with no command waiting: probability %0d, elite_count %0d",
                 out_if.probability, out_if.elite_count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_if.probability !== want.probability) begin
            $error("probability: expected %0d, actual %0d", want.probability,
                   out_if.probability);
            fail_count++;
          end
          if (out_if.elite_count !== want.elite_count) begin
            $error("elite_count: expected %0d, actual %0d", want.elite_count,
                   out_if.elite_count);
            fail_count++;
          end
          if (out_if.done_res !== want.done_res) begin
            $error("done_res: expected %0d, actual %0d", want.done_res, out_if.done_res);
            fail_count++;
          end
        end
      end
      if (long_hold_left > 0) begin
        out_if.ready <= 1'b0;
      end else if (out_stall_left > 0) begin
        out_stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (idling_enabled && $urandom_range(0, 5) == 0) out_stall_left = $urandom_range(1, 17);
      end
    end
  end

  // Guards against a hang anywhere in the run.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("cross_entropy_categorical_update_unit test failed");
      $finish;
    end
  end

  task automatic queue_item(cmd_t cmd, int unsigned row, int unsigned ch);
    cmd_item_t it;
    it.command = cmd;
    it.row_index = ROW_IDX_W'(row);
    it.choice_index = CH_IDX_W'(ch);
    pending_cmds = {pending_cmds, it};
    items_queued++;
  endtask

  // Writes one register on the configuration port and mirrors it in the model.
  // Only the low bits of the data count, so the upper bits of the narrow
  // registers are filled with noise.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RATE:    rate_cfg = data[RATE_W-1:0];
      REG_CHOICES: choices_cfg = data[CHOICES_CFG_W-1:0];
      REG_ROWS:    rows_cfg = data[ROWS_CFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned rate, int unsigned choices, int unsigned rows);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom);
    write_reg(REG_RATE, CFG_DATA_W'(rate));
    write_reg(REG_CHOICES, {noise[CFG_DATA_W-1:CHOICES_CFG_W], CHOICES_CFG_W'(choices)});
    noise = CFG_DATA_W'($urandom);
    write_reg(REG_ROWS, {noise[CFG_DATA_W-1:ROWS_CFG_W], ROWS_CFG_W'(rows)});
  endtask

  // The input side stays quiet until every command queued so far has its
  // result back; registers are only written at such points.
  task automatic wait_drained();
    while (results_seen != items_queued) @(posedge clk);
  endtask

  // A typical learning round: a batch of elite-sample counts, mostly inside
  // the rows and options in use, with reads mixed in, then the update and a
  // few reads of the blended rows. Some rounds restart from uniform.
  task automatic queue_round(int unsigned n_counts);
    int unsigned nr;
    int unsigned nc;
    nr = rows_limit();
    nc = choices_limit();
    if ($urandom_range(0, 9) == 0) queue_item(CMD_INIT, $urandom_range(0, 63),
                                              $urandom_range(0, 15));
    for (int unsigned i = 0; i < n_counts; i++) begin
      if ($urandom_range(0, 99) < 85)
        queue_item(CMD_COUNT, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1));
      else
        queue_item(CMD_COUNT, $urandom_range(0, 63), $urandom_range(0, 15));
      if ($urandom_range(0, 99) < 15)
        queue_item(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 15));
    end
    queue_item(CMD_UPDATE, $urandom_range(0, 63), $urandom_range(0, 15));
    repeat (3) queue_item(CMD_READ, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1));
  endtask

  initial begin : run_test
    int unsigned rows_pick;
    idling_enabled = 1'b1;
    rate_cfg = RATE_RESET;
    choices_cfg = CHOICES_RESET;
    rows_cfg = ROWS_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings. The uniform init comes first so
    // that every probability of the table is written before anything reads it.
    queue_item(CMD_INIT, 0, 0);
    queue_item(CMD_READ, 0, 0);
    queue_item(CMD_READ, 63, 15);
    repeat (3) queue_item(CMD_COUNT, 5, 3);
    queue_item(CMD_COUNT, 5, 7);
    queue_item(CMD_COUNT, 63, 15);
    queue_item(CMD_READ, 5, 3);
    queue_item(CMD_READ, 5, 7);
    queue_item(CMD_UPDATE, 0, 0);
    queue_item(CMD_READ, 5, 3);
    queue_item(CMD_READ, 5, 7);
    queue_item(CMD_READ, 5, 0);
    queue_item(CMD_READ, 63, 15);
    wait_drained();

    // Zero sizes act as a single row and option; counts outside are dropped.
    // The full rate replaces the row by its frequencies, and a uniform init
    // over one option saturates just below 1.0.
    set_config(16'hFFFF, 0, 0);
    queue_item(CMD_COUNT, 0, 0);
    queue_item(CMD_COUNT, 0, 1);
    queue_item(CMD_COUNT, 1, 0);
    queue_item(CMD_READ, 0, 0);
    queue_item(CMD_UPDATE, 0, 0);
    queue_item(CMD_READ, 0, 0);
    queue_item(CMD_READ, 0, 1);
    queue_item(CMD_INIT, 0, 0);
    queue_item(CMD_READ, 0, 0);
    queue_item(CMD_READ, 0, 1);
    queue_item(CMD_READ, 1, 0);
    wait_drained();

    // Saturation of one count, with the long receiver hold-off landing here
    // while the input side keeps offering commands.
    set_config($urandom_range(0, 65535), 16, 2);
    repeat (258) queue_item(CMD_COUNT, 1, 9);
    repeat (3) queue_item(CMD_COUNT, 1, 2);
    queue_item(CMD_READ, 1, 9);
    queue_item(CMD_UPDATE, 0, 0);
    queue_item(CMD_READ, 1, 9);
    queue_item(CMD_READ, 1, 2);
    queue_item(CMD_READ, 0, 0);
    wait_drained();

    // Register values above the table size clamp to it (rate 0), then the exact table size at the top rate.
    set_config(0, 31, 127);
    queue_round(30);
    queue_item(CMD_INIT, 0, 0);
    wait_drained();
    set_config(16'hFFFF, 16, 64);
    queue_round(30);
    wait_drained();

    // Random settings, mostly with few rows so updates stay short.
    while (items_queued < 860) begin
      rows_pick = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
      set_config($urandom_range(0, 65535), $urandom_range(0, 31), rows_pick);
      repeat (3) queue_round($urandom_range(5, 30));
      wait_drained();
    end

    // Closing stretch at full speed on both sides.
    idling_enabled = 1'b0;
    set_config($urandom_range(0, 65535), $urandom_range(1, 16), $urandom_range(1, 8));
    repeat (2) queue_round($urandom_range(10, 20));
    wait_drained();

    repeat (100) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("cross_entropy_categorical_update_unit test passed");
    end else begin
      $display("cross_entropy_categorical_update_unit test failed");
    end
    $finish;
  end

endmodule

// ----- cross_entropy_categorical_update_unit.f -----
rtl/ced_pkg.sv
rtl/ced_if.sv
rtl/ced_div.sv
rtl/ced_dp.sv
rtl/ced_ctrl.sv
rtl/cross_entropy_categorical_update_unit.sv
verif/tb_cross_entropy_categorical_update_unit.sv
